FILE: hw/rtl/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg: shared types and constants for the homogeneous transform engine
// Element types, matrix types, operation codes and the control bundle that
// the top level hands to the matrix store.
// ----------------------------------------------------------------------------
package hte_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int WORD_W = 32;
  localparam int PROD_W = 2 * WORD_W;    // exact signed product
  localparam int SUM_W  = PROD_W + 2;    // exact sum of four products
  localparam int RND_W  = SUM_W + 1;     // sum plus rounding offset

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t vec_t [4];
  typedef word_t mat_t [4][4];

  typedef enum logic [1:0] {
    MODE_IDENT   = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_COMPOSE = 2'd2,
    MODE_XFORM   = 2'd3
  } mode_t;

  // Update requests for the stored and pending matrices.
  typedef struct packed {
    logic       set_identity;
    logic       write_col;
    logic [1:0] wr_col;
    logic       write_pend;
    logic       commit;
    logic [1:0] pend_col;
  } mat_ctrl_t;

endpackage

FILE: hw/rtl/hte_matrix.sv
// ----------------------------------------------------------------------------
// hte_matrix: stored and pending 4x4 matrices
// Holds the transform matrix and the pending product matrix, and applies
// identity loads, column writes, pending column writes and commits.
// ----------------------------------------------------------------------------
module hte_matrix #(
  parameter int FRAC_BITS = hte_pkg::FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  hte_pkg::mat_ctrl_t ctrl,
  input  hte_pkg::vec_t      col_data,
  input  hte_pkg::vec_t      pend_data,
  output hte_pkg::mat_t      xform
);
  import hte_pkg::*;

  localparam word_t ONE = word_t'(1) << FRAC_BITS;

  mat_t tm;
  mat_t pm;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          tm[i][j] <= (i == j) ? ONE : '0;
          pm[i][j] <= '0;
        end
      end
    end else begin
      if (ctrl.set_identity) begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) begin
            tm[i][j] <= (i == j) ? ONE : '0;
          end
        end
      end else if (ctrl.write_col) begin
        for (int i = 0; i < 4; i++) begin
          tm[i][ctrl.wr_col] <= col_data[i];
        end
      end else if (ctrl.commit) begin
        // The column arriving now lands in both matrices in the same cycle.
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) begin
            tm[i][j] <= (2'(j) == ctrl.pend_col) ? pend_data[i] : pm[i][j];
          end
        end
      end
      if (ctrl.write_pend) begin
        for (int i = 0; i < 4; i++) begin
          pm[i][ctrl.pend_col] <= pend_data[i];
        end
      end
    end
  end

  assign xform = tm;

endmodule

FILE: hw/rtl/hte_lane.sv
// ----------------------------------------------------------------------------
// hte_lane: one dot-product lane
// Four registered 32x32 products, registered pair sums, then rounding to
// nearest with ties upward and saturation to 32 bits.
// ----------------------------------------------------------------------------
module hte_lane #(
  parameter int FRAC_BITS = hte_pkg::FRAC_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           en_mul,
  input  logic           en_sum,
  input  hte_pkg::vec_t  a,
  input  hte_pkg::vec_t  b,
  output hte_pkg::word_t result,
  output logic           sat
);
  import hte_pkg::*;

  localparam logic signed [RND_W-1:0] HALF  = RND_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] MAX_V = RND_W'(32'h7fff_ffff);
  localparam logic signed [RND_W-1:0] MIN_V = -MAX_V - RND_W'(1);

  logic signed [PROD_W-1:0] prod [4];
  logic signed [SUM_W-1:0]  pair [2];
  logic signed [RND_W-1:0]  total;
  logic signed [RND_W-1:0]  shifted;
  logic                     over_hi;
  logic                     over_lo;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= PROD_W'(a[k]) * PROD_W'(b[k]);
      end
    end
    if (en_sum) begin
      pair[0] <= SUM_W'(prod[0]) + SUM_W'(prod[1]);
      pair[1] <= SUM_W'(prod[2]) + SUM_W'(prod[3]);
    end
  end

  always_comb begin
    total   = RND_W'(pair[0]) + RND_W'(pair[1]) + HALF;
    shifted = total >>> FRAC_BITS;
    over_hi = shifted > MAX_V;
    over_lo = shifted < MIN_V;
    sat     = over_hi || over_lo;
    if (over_hi) begin
      result = word_t'(32'h7fff_ffff);
    end else if (over_lo) begin
      result = word_t'(32'h8000_0000);
    end else begin
      result = shifted[WORD_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/hte_merge.sv
// ----------------------------------------------------------------------------
// hte_merge: lane merge and result register
// Gathers the four lane results into one vertex, combines the clip flags
// and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module hte_merge (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  hte_pkg::vec_t  res,
  input  logic [3:0]     lane_sat,
  output logic           free,
  output logic           out_valid,
  input  logic           out_ready,
  output hte_pkg::word_t out_x,
  output hte_pkg::word_t out_y,
  output hte_pkg::word_t out_z,
  output hte_pkg::word_t out_w,
  output logic           saturated
);
  import hte_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x     <= res[0];
      out_y     <= res[1];
      out_z     <= res[2];
      out_w     <= res[3];
      saturated <= |lane_sat;
    end
  end

endmodule

FILE: hw/rtl/homogeneous_transform_engine.sv
// ----------------------------------------------------------------------------
// homogeneous_transform_engine: 4x4 Q-format homogeneous transform
// Keeps a fixed-point transform matrix, composes it with right-hand columns
// and transforms vertices in four parallel dot-product lanes.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | mode, column, in_x, in_y, in_z, in_w, commit
//  out     | out_valid / out_ready| out_x, out_y, out_z, out_w, saturated
//
// One transaction is accepted per cycle unless a stall or a commit holds the
// input. A vertex passes the operand, product and pair-sum stages, then the
// output register. A compose transaction with commit set locks the input until
// it leaves the three-stage arithmetic pipe.
// Reset loads the identity matrix, clears the pending matrix and empties the
// pipe; the input is ready in the first cycle after reset.
// A stalled output holds only the output register and a vertex in stage 3
// with the full stages behind it; empty stages keep taking transactions.
//
// Lane l computes one dot product. For a vertex, lane l works on column l of
// the stored matrix and yields output component l. For a compose step, lane l
// works on row l and yields row l of the pending column. The merge stage
// gathers the four lanes into the result register or the pending matrix.
// Identity loads and column writes take effect at the accepting clock edge,
// so the very next transaction already sees them.
// ----------------------------------------------------------------------------
module homogeneous_transform_engine #(
  parameter int FRAC_BITS = hte_pkg::FRAC_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     mode,
  input  logic [1:0]     column,
  input  hte_pkg::word_t in_x,
  input  hte_pkg::word_t in_y,
  input  hte_pkg::word_t in_z,
  input  hte_pkg::word_t in_w,
  input  logic           commit,
  output logic           out_valid,
  input  logic           out_ready,
  output hte_pkg::word_t out_x,
  output hte_pkg::word_t out_y,
  output hte_pkg::word_t out_z,
  output hte_pkg::word_t out_w,
  output logic           saturated
);
  import hte_pkg::*;

  localparam word_t ONE = word_t'(1) << FRAC_BITS;

  // Matrix store.
  mat_ctrl_t ctrl;
  mat_t      xform;
  vec_t      in_vec;
  vec_t      lane_res;
  logic [3:0] lane_sat;

  // Pipe stage 1: operands. Stage 2: products. Stage 3: pair sums.
  logic       v1, v2, v3;
  logic       x1, x2, x3;         // transaction is a vertex transform
  logic       c1, c2, c3;         // compose with commit
  logic [1:0] col1, col2, col3;
  mat_t       op_a;
  vec_t       op_b;

  logic accept;
  logic enter;
  logic ld2, ld3, retire3;
  logic merge_free;
  logic commit_busy;

  assign in_vec = '{in_x, in_y, in_z, in_w};

  // A commit rewrites the whole stored matrix when it retires, so nothing
  // may read or write that matrix while one is in flight.
  assign commit_busy = (v1 && c1) || (v2 && c2) || (v3 && c3);

  assign retire3  = v3 && (!x3 || merge_free);
  assign ld3      = v2 && (!v3 || retire3);
  assign ld2      = v1 && (!v2 || ld3);
  assign in_ready = (!v1 || ld2) && !commit_busy;
  assign accept   = in_valid && in_ready;
  assign enter    = accept && (mode == MODE_COMPOSE || mode == MODE_XFORM);

  always_comb begin
    ctrl              = '0;
    ctrl.set_identity = accept && (mode == MODE_IDENT);
    ctrl.write_col    = accept && (mode == MODE_WRITE);
    ctrl.wr_col       = column;
    ctrl.write_pend   = retire3 && !x3;
    ctrl.commit       = retire3 && c3;
    ctrl.pend_col     = col3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (enter) begin
        v1 <= 1'b1;
      end else if (ld2) begin
        v1 <= 1'b0;
      end
      if (ld2) begin
        v2 <= 1'b1;
      end else if (ld3) begin
        v2 <= 1'b0;
      end
      if (ld3) begin
        v3 <= 1'b1;
      end else if (retire3) begin
        v3 <= 1'b0;
      end
    end
  end

  // Stage tags. The commit tags only count while the stage is valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= 1'b0;
      c2 <= 1'b0;
      c3 <= 1'b0;
    end else begin
      if (enter) begin
        c1 <= (mode == MODE_COMPOSE) && commit;
      end
      if (ld2) begin
        c2 <= c1;
      end
      if (ld3) begin
        c3 <= c2;
      end
    end
  end

  // Operand capture: columns of the stored matrix for a vertex, rows for a
  // compose step.
  always_ff @(posedge clk) begin
    if (enter) begin
      x1   <= (mode == MODE_XFORM);
      col1 <= column;
      op_b <= in_vec;
      for (int l = 0; l < 4; l++) begin
        for (int k = 0; k < 4; k++) begin
          op_a[l][k] <= (mode == MODE_XFORM) ? xform[k][l] : xform[l][k];
        end
      end
    end
    if (ld2) begin
      x2   <= x1;
      col2 <= col1;
    end
    if (ld3) begin
      x3   <= x2;
      col3 <= col2;
    end
  end

  hte_matrix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_matrix (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .col_data  (in_vec),
    .pend_data (lane_res),
    .xform     (xform)
  );

  for (genvar l = 0; l < 4; l++) begin : g_lane
    hte_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en_mul (ld2),
      .en_sum (ld3),
      .a      (op_a[l]),
      .b      (op_b),
      .result (lane_res[l]),
      .sat    (lane_sat[l])
    );
  end

  hte_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (retire3 && x3),
    .res       (lane_res),
    .lane_sat  (lane_sat),
    .free      (merge_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w),
    .saturated (saturated)
  );

  // At most one committing compose is ever in the pipe.
  a_single_commit: assert property (@(posedge clk) disable iff (rst)
    $countones({v1 && c1, v2 && c2, v3 && c3}) <= 1)
    else $error("more than one commit in flight");

  // A vertex only enters the result register when that register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (retire3 && x3) |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // An identity transaction leaves the identity diagonal in the next cycle.
  a_identity: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_IDENT) |=>
      (xform[0][0] == ONE && xform[3][3] == ONE && xform[0][1] == '0))
    else $error("identity load failed");

  // Nothing is accepted while a commit is still on its way to the matrix.
  a_commit_lock: assert property (@(posedge clk) disable iff (rst)
    (v3 && c3) |-> !accept)
    else $error("transaction accepted during commit");

endmodule

FILE: verif/homogeneous_transform_engine_test.sv
// ----------------------------------------------------------------------------
// homogeneous_transform_engine_test: self-checking bench for the transform engine
// Mirrors the stored and pending matrices in Q16.16, predicts every vertex
// that the engine returns and compares it field by field. Directed cases
// cover rounding ties, saturation and partial commits. Random traffic follows
// in phases with different amounts of idling on both channels.
// ----------------------------------------------------------------------------
module homogeneous_transform_engine_test;
  import hte_pkg::*;

  localparam int FRAC_BITS  = FRAC_BITS_DEFAULT;
  localparam int LONG_HOLD  = 300;  // cycles the receiver refuses vertices
  localparam int DRAIN_WAIT = 10;   // cycles watched after the last vertex

  localparam word_t ONE  = word_t'(1) <<< FRAC_BITS;
  localparam word_t WMAX = 32'sh7FFF_FFFF;
  localparam word_t WMIN = 32'sh8000_0000;

  // Keeps its own copy of both matrices and the vertices still owed.
  class transform_mirror;
    typedef logic signed [SUM_W+1:0] acc_t;
    typedef struct {
      word_t x, y, z, w;
      bit    clipped;
    } vertex_t;

    mat_t    stored;
    mat_t    pending;
    vertex_t expected_vertices[$];
    int      errors;

    function new();
      load_identity();
      foreach (pending[i, j]) pending[i][j] = '0;
      errors = 0;
    endfunction

    function void load_identity();
      foreach (stored[i, j]) stored[i][j] = (i == j) ? ONE : '0;
    endfunction

    // Exact sum of four products, rounded half up, clipped to 32 bits.
    function word_t fixed_dot(input vec_t a, input vec_t b, inout bit clipped);
      acc_t acc;
      acc = '0;
      for (int k = 0; k < 4; k++) acc += acc_t'(a[k]) * acc_t'(b[k]);
      acc = (acc + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (acc > acc_t'(WMAX)) begin
        clipped = 1'b1;
        return WMAX;
      end
      if (acc < acc_t'(WMIN)) begin
        clipped = 1'b1;
        return WMIN;
      end
      return word_t'(acc);
    endfunction

    function void apply_transaction(mode_t m, logic [1:0] col, word_t x, word_t y,
                                    word_t z, word_t w, logic cm);
      vec_t    v;
      vec_t    lane;
      vec_t    res;
      vertex_t vx;
      bit      clip;
      v = '{x, y, z, w};
      clip = 1'b0;
      case (m)
        MODE_IDENT: begin
          load_identity();
        end
        MODE_WRITE: begin
          for (int i = 0; i < 4; i++) stored[i][col] = v[i];
        end
        MODE_COMPOSE: begin
          // The clip flag of a compose step is dropped on purpose.
          for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) lane[k] = stored[i][k];
            pending[i][col] = fixed_dot(lane, v, clip);
          end
          if (cm) stored = pending;
        end
        MODE_XFORM: begin
          for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 4; k++) lane[k] = stored[k][j];
            res[j] = fixed_dot(v, lane, clip);
          end
          vx.x = res[0];
          vx.y = res[1];
          vx.z = res[2];
          vx.w = res[3];
          vx.clipped = clip;
          expected_vertices.push_back(vx);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_vertex(word_t x, word_t y, word_t z, word_t w, logic sat);
      vertex_t exp_v;
      if (expected_vertices.size() == 0) begin
        $error("vertex (%0d, %0d, %0d, %0d) arrived with none outstanding", x, y, z, w);
        errors++;
        return;
      end
      exp_v = expected_vertices.pop_front();
      if (x !== exp_v.x) begin
        $error("out_x: expected %0d, got %0d", exp_v.x, x);
        errors++;
      end
      if (y !== exp_v.y) begin
        $error("out_y: expected %0d, got %0d", exp_v.y, y);
        errors++;
      end
      if (z !== exp_v.z) begin
        $error("out_z: expected %0d, got %0d", exp_v.z, z);
        errors++;
      end
      if (w !== exp_v.w) begin
        $error("out_w: expected %0d, got %0d", exp_v.w, w);
        errors++;
      end
      if (sat !== exp_v.clipped) begin
        $error("saturated: expected %0d, got %0d", exp_v.clipped, sat);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] mode;
  logic [1:0] column;
  word_t      in_x, in_y, in_z, in_w;
  logic       commit;
  logic       out_valid;
  logic       out_ready;
  word_t      out_x, out_y, out_z, out_w;
  logic       saturated;

  transform_mirror mirror;
  int tx_idle_pct;
  int rx_stall_pct;
  int sent_count;
  bit hold_request;

  homogeneous_transform_engine #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .column(column),
    .in_x(in_x),
    .in_y(in_y),
    .in_z(in_z),
    .in_w(in_w),
    .commit(commit),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .out_w(out_w),
    .saturated(saturated)
  );

  always #10 clk = ~clk;

  // Uniform value in [-span, span].
  function automatic word_t small_q(int unsigned span);
    return word_t'($urandom_range(2 * span)) - word_t'(span);
  endfunction

  // Mix of corner values, raw 32-bit patterns and moderate Q16.16 values.
  function automatic word_t any_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      case ($urandom_range(5))
        0: return WMAX;
        1: return WMIN;
        2: return '0;
        3: return -1;
        4: return ONE;
        default: return -ONE;
      endcase
    end
    if (pick < 40) return word_t'($urandom);
    return small_q(4 << FRAC_BITS);
  endfunction

  // Offers one transaction, after a random gap, and waits for its acceptance.
  task automatic offer_transaction(mode_t m, logic [1:0] col, word_t x, word_t y,
                                   word_t z, word_t w, logic cm);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    mode     <= m;
    column   <= col;
    in_x     <= x;
    in_y     <= y;
    in_z     <= z;
    in_w     <= w;
    commit   <= cm;
    do @(posedge clk); while (!in_ready);
    mirror.apply_transaction(m, col, x, y, z, w, cm);
    sent_count++;
  endtask

  // Column and commit are don't-cares for a vertex, so they are randomized.
  task automatic send_vertex(word_t x, word_t y, word_t z, word_t w);
    offer_transaction(MODE_XFORM, 2'($urandom), x, y, z, w, 1'($urandom));
  endtask

  task automatic wait_drained();
    while (mirror.expected_vertices.size() != 0) @(posedge clk);
  endtask

  // Four compose steps; the last one commits when asked.
  task automatic compose_matrix(int unsigned span, bit do_commit);
    for (int c = 0; c < 4; c++)
      offer_transaction(MODE_COMPOSE, 2'(c), small_q(span), small_q(span), small_q(span),
                        small_q(span), (c == 3) ? do_commit : 1'b0);
  endtask

  task automatic run_directed();
    // Identity passes vertices through unchanged, extremes included.
    send_vertex(ONE, -ONE, 32'sd3, 32'sh1234_5678);
    send_vertex(WMAX, WMIN, WMIN, WMAX);
    // Values are ignored by an identity load, and commit outside compose does nothing.
    offer_transaction(MODE_IDENT, 2'd3, WMAX, WMIN, -1, 32'sh5A5A_A5A5, 1'b1);
    // A single LSB in the matrix exposes rounding ties, which go toward +inf.
    offer_transaction(MODE_WRITE, 2'd0, 32'sd1, '0, '0, '0, 1'b1);
    send_vertex(32'sh0000_8000, '0, '0, '0);
    send_vertex(-32'sh0000_8000, '0, '0, '0);
    // Extreme columns drive the dot products into both saturation limits.
    offer_transaction(MODE_WRITE, 2'd1, WMAX, WMAX, WMAX, WMAX, 1'b0);
    offer_transaction(MODE_WRITE, 2'd2, WMIN, WMIN, WMIN, WMIN, 1'b0);
    send_vertex(WMAX, WMAX, WMAX, WMAX);
    send_vertex(WMIN, WMIN, WMIN, WMIN);
    send_vertex(WMIN, WMAX, WMIN, WMAX);
    // A commit with only one pending column copies the rest as zeros.
    offer_transaction(MODE_IDENT, 2'd0, '0, '0, '0, '0, 1'b0);
    offer_transaction(MODE_COMPOSE, 2'd1, '0, 2 * ONE, '0, '0, 1'b1);
    send_vertex(ONE, ONE, ONE, ONE);
    // Identity leaves the pending matrix alone; a new commit brings it back.
    offer_transaction(MODE_IDENT, 2'd2, '0, '0, '0, '0, 1'b0);
    offer_transaction(MODE_COMPOSE, 2'd3, small_q(ONE), small_q(ONE), ONE, ONE, 1'b1);
    send_vertex(ONE, -ONE, ONE, ONE);
    // A full compose with a commit, then a saturating compose that clips silently.
    offer_transaction(MODE_IDENT, 2'd0, '0, '0, '0, '0, 1'b0);
    compose_matrix(2 << FRAC_BITS, 1'b1);
    send_vertex(small_q(ONE), small_q(ONE), small_q(ONE), ONE);
    offer_transaction(MODE_WRITE, 2'd0, WMAX, WMAX, WMAX, WMAX, 1'b0);
    offer_transaction(MODE_COMPOSE, 2'd0, WMAX, WMAX, WMAX, WMAX, 1'b1);
    send_vertex(32'sd1, -32'sd1, '0, '0);
    offer_transaction(MODE_IDENT, 2'd1, '0, '0, '0, '0, 1'b0);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned target;
    int unsigned pick;
    target = sent_count + count;
    while (sent_count < target) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_vertex(any_word(), any_word(), any_word(), any_word());
      end else if (pick < 55) begin
        if ($urandom_range(3) == 0)
          offer_transaction(MODE_WRITE, 2'($urandom), any_word(), any_word(), any_word(),
                            any_word(), 1'($urandom));
        else
          offer_transaction(MODE_WRITE, 2'($urandom), small_q(2 << FRAC_BITS),
                            small_q(2 << FRAC_BITS), small_q(2 << FRAC_BITS), ONE,
                            1'($urandom));
      end else if (pick < 70) begin
        compose_matrix(2 << FRAC_BITS, 1'b1);
      end else if (pick < 76) begin
        offer_transaction(MODE_IDENT, 2'($urandom), any_word(), any_word(), any_word(),
                          any_word(), 1'($urandom));
      end else if (pick < 84) begin
        // Stray compose step: random column and commit, wild values.
        offer_transaction(MODE_COMPOSE, 2'($urandom), any_word(), any_word(), any_word(),
                          any_word(), 1'($urandom));
      end else begin
        repeat ($urandom_range(8, 4))
          send_vertex(small_q(8 << FRAC_BITS), small_q(8 << FRAC_BITS),
                      small_q(8 << FRAC_BITS), ONE);
      end
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
      end
      out_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      mirror.check_vertex(out_x, out_y, out_z, out_w, saturated);
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int tx_pct[4];
    int rx_pct[4];
    tx_pct = '{0, 64, 0, 32};
    rx_pct = '{0, 0, 64, 32};
    mirror = new();
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_IDENT;
    column = '0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    in_w = '0;
    commit = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    sent_count = 0;
    hold_request = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      run_random(225);
      if (p == 0) begin
        // Receiver blocks for a long stretch while vertices keep coming,
        // so the pipe fills and in_ready must drop.
        hold_request = 1'b1;
        repeat (40)
          send_vertex(small_q(4 << FRAC_BITS), small_q(4 << FRAC_BITS),
                      small_q(4 << FRAC_BITS), ONE);
        // The sender goes quiet until every vertex owed has come back.
        in_valid <= 1'b0;
        wait_drained();
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mirror.errors == 0 && mirror.expected_vertices.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
